FILE: rtl/bcp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bcp_pkg;

	// fixed point format of coordinates, coefficients and pixel results
	localparam int FRAC_BITS = 16;
	localparam int COORD_W   = 32;
	localparam int COEF_W    = 32;

	// configuration port
	localparam int CFG_W    = 64;
	localparam int NUM_REGS = 6;
	localparam int IDX_W    = $clog2(NUM_REGS);

	localparam logic [IDX_W-1:0] REG_COEF_0_1   = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_COEF_2_3   = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_COEF_4_5   = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_COEF_6_7   = IDX_W'(3);
	localparam logic [IDX_W-1:0] REG_COEF_8_9   = IDX_W'(4);
	localparam logic [IDX_W-1:0] REG_COEF_10_11 = IDX_W'(5);

	// digit-serial multiplier
	localparam int DIGIT_W    = 8;
	localparam int NUM_DIGITS = COORD_W / DIGIT_W;
	localparam int DIG_CNT_W  = $clog2(NUM_DIGITS);
	localparam int PP_W       = COEF_W + DIGIT_W + 1;
	localparam int T_W        = PP_W + 1;
	localparam int HI_W       = T_W - DIGIT_W;
	localparam int NUM_TERMS  = 3;
	localparam int K_W        = $clog2(NUM_TERMS);

	// floored product and row sum
	localparam int PROD_W = COEF_W + COORD_W - FRAC_BITS;
	localparam int ACC_W  = PROD_W + 2;

	// bit-serial divider: quotient bits kept before saturation
	localparam int QUO_W     = COORD_W + 1;
	localparam int DIV_CNT_W = $clog2(QUO_W);

	// |w| at or below this counts as below 1e-6
	localparam longint TINY_MAX = ((64'sd1 << FRAC_BITS) - 1) / 1000000;

	localparam logic signed [COORD_W-1:0] Q_MAX   = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] Q_MIN   = {1'b1, {(COORD_W-1){1'b0}}};
	localparam logic signed [COORD_W-1:0] NEG_ONE = COORD_W'(-(64'sd1 << FRAC_BITS));

endpackage

`default_nettype wire

FILE: rtl/bcp_corner_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bcp_corner_if import bcp_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] corner_x;
	logic signed [COORD_W-1:0] corner_y;
	logic signed [COORD_W-1:0] corner_z;
	logic                      last_corner;

	modport source (output valid, output corner_x, output corner_y, output corner_z,
		output last_corner, input ready);
	modport sink (input valid, input corner_x, input corner_y, input corner_z,
		input last_corner, output ready);
endinterface

`default_nettype wire

FILE: rtl/bcp_box_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bcp_box_if import bcp_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] box_left;
	logic signed [COORD_W-1:0] box_top;
	logic signed [COORD_W-1:0] box_right;
	logic signed [COORD_W-1:0] box_bottom;
	logic                      box_valid;

	modport source (output valid, output box_left, output box_top, output box_right,
		output box_bottom, output box_valid, input ready);
	modport sink (input valid, input box_left, input box_top, input box_right,
		input box_bottom, input box_valid, output ready);
endinterface

`default_nettype wire

FILE: rtl/bcp_dot.sv
`timescale 1ns / 1ps
`default_nettype none

module bcp_dot import bcp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [COEF_W-1:0]  coef0,
	input  logic signed [COEF_W-1:0]  coef1,
	input  logic signed [COEF_W-1:0]  coef2,
	input  logic signed [COEF_W-1:0]  offset,
	input  logic signed [COORD_W-1:0] x,
	input  logic signed [COORD_W-1:0] y,
	input  logic signed [COORD_W-1:0] z,
	output logic                      done,
	output logic signed [ACC_W-1:0]   dot
);

	logic                      busy_q;
	logic                      prod_vld_q;
	logic                      prod_last_q;
	logic                      done_q;
	logic [K_W-1:0]            k_q;
	logic [DIG_CNT_W-1:0]      dig_q;
	logic signed [COEF_W-1:0]  mcand_q;
	logic [COORD_W-1:0]        mplier_q;
	logic signed [HI_W-1:0]    hi_q;
	logic [COORD_W-1:0]        lo_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]   acc_q;

	logic                      top_digit;
	logic                      dig_end;
	logic signed [DIGIT_W:0]   dsig;
	logic signed [PP_W-1:0]    pp;
	logic signed [T_W-1:0]     t;
	logic signed [HI_W-1:0]    hi_nxt;
	logic [COORD_W-1:0]        lo_nxt;

	// one digit of the multiplier per cycle, lower digits unsigned, top digit signed
	assign top_digit = (dig_q == DIG_CNT_W'(NUM_DIGITS - 1));
	assign dig_end   = top_digit;
	assign dsig      = {top_digit & mplier_q[DIGIT_W-1], mplier_q[DIGIT_W-1:0]};
	assign pp        = PP_W'(mcand_q) * PP_W'(dsig);
	assign t         = T_W'(hi_q) + T_W'(pp);
	assign hi_nxt    = HI_W'(t >>> DIGIT_W);
	assign lo_nxt    = {t[DIGIT_W-1:0], lo_q[COORD_W-1:DIGIT_W]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			prod_vld_q  <= 1'b0;
			prod_last_q <= 1'b0;
			done_q      <= 1'b0;
			k_q         <= '0;
			dig_q       <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q     <= 1'b1;
				prod_vld_q <= 1'b0;
				k_q        <= '0;
				dig_q      <= '0;
			end else begin
				if (prod_vld_q) begin
					prod_vld_q <= 1'b0;
					done_q     <= prod_last_q;
				end
				if (busy_q) begin
					dig_q <= dig_q + 1'b1;
					if (dig_end) begin
						prod_vld_q  <= 1'b1;
						prod_last_q <= (k_q == K_W'(NUM_TERMS - 1));
						if (k_q == K_W'(NUM_TERMS - 1)) begin
							busy_q <= 1'b0;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= ACC_W'(offset);
			mcand_q  <= coef0;
			mplier_q <= x;
			hi_q     <= '0;
		end else begin
			// floored product of the previous term folds in while the next one runs
			if (prod_vld_q) begin
				acc_q <= acc_q + ACC_W'(prod_q);
			end
			if (busy_q) begin
				lo_q <= lo_nxt;
				if (dig_end) begin
					prod_q <= {hi_nxt[COEF_W-1:0], lo_nxt[COORD_W-1:FRAC_BITS]};
					hi_q   <= '0;
					if (k_q == '0) begin
						mcand_q  <= coef1;
						mplier_q <= y;
					end else begin
						mcand_q  <= coef2;
						mplier_q <= z;
					end
				end else begin
					hi_q     <= hi_nxt;
					mplier_q <= mplier_q >> DIGIT_W;
				end
			end
		end
	end

	assign done = done_q;
	assign dot  = acc_q;

endmodule

`default_nettype wire

FILE: rtl/bcp_div.sv
`timescale 1ns / 1ps
`default_nettype none

module bcp_div import bcp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [ACC_W-1:0]   num,
	input  logic signed [ACC_W-1:0]   den,
	output logic                      done,
	output logic signed [COORD_W-1:0] quo
);

	typedef enum logic [1:0] {D_IDLE, D_CHK, D_ITER, D_FIN} dstate_t;

	dstate_t                   state_q;
	logic [DIV_CNT_W-1:0]      cnt_q;
	logic                      neg_q;
	logic                      ovf_q;
	logic                      done_q;
	logic signed [COORD_W-1:0] quo_q;
	logic [ACC_W-1:0]          dmag_q;
	logic [ACC_W-1:0]          rem_q;
	logic [QUO_W-1:0]          shreg_q;

	logic [ACC_W-1:0]          nmag;
	logic [ACC_W-1:0]          dmag;
	logic [ACC_W:0]            rem_sh;
	logic [ACC_W+1:0]          diff;
	logic                      ge;
	logic                      big;
	logic signed [COORD_W-1:0] fin_val;

	assign nmag = num[ACC_W-1] ? -num : num;
	assign dmag = den[ACC_W-1] ? -den : den;

	// restoring step: next dividend bit comes off the top of the shift register,
	// the quotient bit goes in at the bottom
	assign rem_sh = {rem_q, shreg_q[QUO_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, dmag_q};
	assign ge     = !diff[ACC_W+1];

	assign big = |shreg_q[QUO_W-1:COORD_W-1];

	always_comb begin
		if (ovf_q || big) begin
			fin_val = neg_q ? Q_MIN : Q_MAX;
		end else if (neg_q) begin
			fin_val = -shreg_q[COORD_W-1:0];
		end else begin
			fin_val = shreg_q[COORD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
			neg_q   <= 1'b0;
			ovf_q   <= 1'b0;
			done_q  <= 1'b0;
			quo_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (start) begin
						neg_q   <= num[ACC_W-1] ^ den[ACC_W-1];
						state_q <= D_CHK;
					end
				end
				D_CHK: begin
					// quotient would need more than QUO_W bits
					ovf_q   <= (rem_q >= dmag_q);
					cnt_q   <= '0;
					state_q <= D_ITER;
				end
				D_ITER: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_CNT_W'(QUO_W - 1)) begin
						state_q <= D_FIN;
					end
				end
				D_FIN: begin
					quo_q   <= fin_val;
					done_q  <= 1'b1;
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == D_IDLE && start) begin
			dmag_q  <= dmag;
			rem_q   <= ACC_W'(nmag >> (QUO_W - FRAC_BITS));
			shreg_q <= {nmag[QUO_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
		end else if (state_q == D_ITER) begin
			rem_q   <= ge ? diff[ACC_W-1:0] : rem_sh[ACC_W-1:0];
			shreg_q <= {shreg_q[QUO_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

FILE: rtl/box_corner_projection_bbox_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Projects the corners of a 3D box through a 3x4 matrix and reports the 2D
// pixel bounding box. One corner request is taken at a time. A corner with
// depth at or below zero goes straight from S_IDLE to S_FIN. A corner whose w
// is below 1e-6 in magnitude is only dropped once the dot products are done.
// For a corner that projects, three digit-serial dot-product units run side
// by side, 8 bits of the coordinate a cycle over three terms, then
// two bit-serial restoring dividers share the divisor w and produce u/w and v/w
// at one quotient bit a cycle, and the S_UPD and S_FIN states update the
// extremes and close. The request flagged last_corner produces one result in
// the output register; the next corner is accepted while that result waits to
// be taken, but a closing corner waits until the previous result has been
// taken. Coefficient registers are written through cfg_we/cfg_index/cfg_data
// and must only change while the block is idle.

module box_corner_projection_bbox_top import bcp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	bcp_corner_if.sink       corner,
	bcp_box_if.source        box
);

	typedef enum logic [2:0] {S_IDLE, S_START, S_DOT, S_CHK, S_DIV, S_UPD, S_FIN} state_t;

	state_t                    state_q;
	logic [CFG_W-1:0]          regs_q [NUM_REGS];
	logic signed [COORD_W-1:0] x_q;
	logic signed [COORD_W-1:0] y_q;
	logic signed [COORD_W-1:0] z_q;
	logic                      last_q;
	logic signed [COORD_W-1:0] min_u_q;
	logic signed [COORD_W-1:0] max_u_q;
	logic signed [COORD_W-1:0] min_v_q;
	logic signed [COORD_W-1:0] max_v_q;
	logic [1:0]                cnt_q;
	logic                      out_vld_q;
	logic signed [COORD_W-1:0] left_q;
	logic signed [COORD_W-1:0] top_q;
	logic signed [COORD_W-1:0] right_q;
	logic signed [COORD_W-1:0] bottom_q;
	logic                      ok_q;

	logic                      accept;
	logic                      z_pos;
	logic                      dot_start;
	logic                      u_dot_done;
	logic                      v_dot_done;
	logic                      w_dot_done;
	logic signed [ACC_W-1:0]   u_dot;
	logic signed [ACC_W-1:0]   v_dot;
	logic signed [ACC_W-1:0]   w_dot;
	logic [ACC_W-1:0]          w_mag;
	logic                      tiny;
	logic                      div_start;
	logic                      u_done;
	logic                      v_done;
	logic signed [COORD_W-1:0] u_quo;
	logic signed [COORD_W-1:0] v_quo;
	logic                      slot_free;

	assign accept    = corner.valid && corner.ready;
	assign z_pos     = !corner.corner_z[COORD_W-1] && (corner.corner_z != '0);
	assign dot_start = (state_q == S_START);
	assign w_mag     = w_dot[ACC_W-1] ? -w_dot : w_dot;
	assign tiny      = (w_mag <= ACC_W'(TINY_MAX));
	assign div_start = (state_q == S_CHK) && !tiny;
	assign slot_free = !out_vld_q || box.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= '0;
			end
		end else if (cfg_we && cfg_index < IDX_W'(NUM_REGS)) begin
			regs_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= corner.corner_x;
			y_q    <= corner.corner_y;
			z_q    <= corner.corner_z;
			last_q <= corner.last_corner;
		end
	end

	bcp_dot u_row (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dot_start),
		.coef0  (regs_q[REG_COEF_0_1][COEF_W-1:0]),
		.coef1  (regs_q[REG_COEF_0_1][CFG_W-1:COEF_W]),
		.coef2  (regs_q[REG_COEF_2_3][COEF_W-1:0]),
		.offset (regs_q[REG_COEF_2_3][CFG_W-1:COEF_W]),
		.x      (x_q),
		.y      (y_q),
		.z      (z_q),
		.done   (u_dot_done),
		.dot    (u_dot)
	);

	bcp_dot v_row (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dot_start),
		.coef0  (regs_q[REG_COEF_4_5][COEF_W-1:0]),
		.coef1  (regs_q[REG_COEF_4_5][CFG_W-1:COEF_W]),
		.coef2  (regs_q[REG_COEF_6_7][COEF_W-1:0]),
		.offset (regs_q[REG_COEF_6_7][CFG_W-1:COEF_W]),
		.x      (x_q),
		.y      (y_q),
		.z      (z_q),
		.done   (v_dot_done),
		.dot    (v_dot)
	);

	bcp_dot w_row (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dot_start),
		.coef0  (regs_q[REG_COEF_8_9][COEF_W-1:0]),
		.coef1  (regs_q[REG_COEF_8_9][CFG_W-1:COEF_W]),
		.coef2  (regs_q[REG_COEF_10_11][COEF_W-1:0]),
		.offset (regs_q[REG_COEF_10_11][CFG_W-1:COEF_W]),
		.x      (x_q),
		.y      (y_q),
		.z      (z_q),
		.done   (w_dot_done),
		.dot    (w_dot)
	);

	bcp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (u_dot),
		.den    (w_dot),
		.done   (u_done),
		.quo    (u_quo)
	);

	bcp_div v_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (v_dot),
		.den    (w_dot),
		.done   (v_done),
		.quo    (v_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			min_u_q   <= Q_MAX;
			max_u_q   <= Q_MIN;
			min_v_q   <= Q_MAX;
			max_v_q   <= Q_MIN;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
			left_q    <= '0;
			top_q     <= '0;
			right_q   <= '0;
			bottom_q  <= '0;
			ok_q      <= 1'b0;
		end else begin
			if (box.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (corner.valid) begin
						state_q <= z_pos ? S_START : S_FIN;
					end
				end
				S_START: begin
					state_q <= S_DOT;
				end
				S_DOT: begin
					if (u_dot_done && v_dot_done && w_dot_done) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					state_q <= tiny ? S_FIN : S_DIV;
				end
				S_DIV: begin
					if (u_done && v_done) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (u_quo < min_u_q) min_u_q <= u_quo;
					if (u_quo > max_u_q) max_u_q <= u_quo;
					if (v_quo < min_v_q) min_v_q <= v_quo;
					if (v_quo > max_v_q) max_v_q <= v_quo;
					if (cnt_q < 2'd2) begin
						cnt_q <= cnt_q + 1'b1;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!last_q) begin
						state_q <= S_IDLE;
					end else if (slot_free) begin
						out_vld_q <= 1'b1;
						if (cnt_q < 2'd2) begin
							left_q   <= NEG_ONE;
							top_q    <= NEG_ONE;
							right_q  <= NEG_ONE;
							bottom_q <= NEG_ONE;
							ok_q     <= 1'b0;
						end else begin
							left_q   <= min_u_q[COORD_W-1] ? '0 : min_u_q;
							top_q    <= min_v_q[COORD_W-1] ? '0 : min_v_q;
							right_q  <= max_u_q;
							bottom_q <= max_v_q;
							ok_q     <= 1'b1;
						end
						// re-arm for the next box
						min_u_q <= Q_MAX;
						max_u_q <= Q_MIN;
						min_v_q <= Q_MAX;
						max_v_q <= Q_MIN;
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign corner.ready   = (state_q == S_IDLE);
	assign box.valid      = out_vld_q;
	assign box.box_left   = left_q;
	assign box.box_top    = top_q;
	assign box.box_right  = right_q;
	assign box.box_bottom = bottom_q;
	assign box.box_valid  = ok_q;

	// once a corner has been counted the running extremes are ordered
	a_extremes_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != 2'd0) |-> (min_u_q <= max_u_q && min_v_q <= max_v_q))
		else $error("running minimum above running maximum");

	// both quotients share the divisor and finish together
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		u_done == v_done)
		else $error("u and v dividers out of step");

	// closing a box delivers a result and re-arms the accumulators
	a_close_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && last_q && slot_free) |=>
		(box.valid && cnt_q == 2'd0 && min_u_q == Q_MAX && max_v_q == Q_MIN))
		else $error("box close did not emit or re-arm");

	// no new corner while a division is outstanding
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> !corner.ready)
		else $error("corner accepted during division");

endmodule

`default_nettype wire

FILE: bench/tb_box_corner_projection_bbox_top.sv
`timescale 1ns / 1ps

module tb_box_corner_projection_bbox_top;
	import bcp_pkg::*;

	localparam int ONE          = 1 << FRAC_BITS;
	localparam int SETTLE_CYCLES = 120;
	localparam int HOLD_CYCLES   = 600;

	localparam logic [IDX_W-1:0] REG_ORDER [NUM_REGS] = '{REG_COEF_0_1, REG_COEF_2_3,
		REG_COEF_4_5, REG_COEF_6_7, REG_COEF_8_9, REG_COEF_10_11};
	// indexes past the register list, writes there must be dropped
	localparam logic [IDX_W-1:0] REG_UNUSED_A = IDX_W'(NUM_REGS);
	localparam logic [IDX_W-1:0] REG_UNUSED_B = IDX_W'(NUM_REGS + 1);

	typedef enum {MAT_CAMERA, MAT_TILTED, MAT_RAND_CAMERA, MAT_MAX, MAT_MIN, MAT_RANDOM}
		matrix_kind_t;
	typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] box_left;
		logic signed [COORD_W-1:0] box_top;
		logic signed [COORD_W-1:0] box_right;
		logic signed [COORD_W-1:0] box_bottom;
		logic                      box_valid;
	} bbox_t;

	class bbox_tracker;
		logic [CFG_W-1:0]          coef_reg [NUM_REGS];
		logic signed [COORD_W-1:0] min_u, max_u, min_v, max_v;
		int                        good_corners;
		bbox_t                     pending_boxes [$];
		int                        errors;
		int                        corners_seen;
		int                        boxes_checked;
		int                        valid_boxes;

		function new();
			foreach (coef_reg[i])
				coef_reg[i] = '0;
			errors = 0;
			corners_seen = 0;
			boxes_checked = 0;
			valid_boxes = 0;
			rearm();
		endfunction

		function void rearm();
			min_u = Q_MAX;
			max_u = Q_MIN;
			min_v = Q_MAX;
			max_v = Q_MIN;
			good_corners = 0;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			if (idx < NUM_REGS)
				coef_reg[idx] = val;
		endfunction

		function longint coef_of(int k);
			logic [CFG_W-1:0] r;
			r = coef_reg[k / 2];
			if (k % 2)
				return longint'(signed'(r[2*COEF_W-1:COEF_W]));
			return longint'(signed'(r[COEF_W-1:0]));
		endfunction

		// each product floored to FRAC_BITS, then summed exactly with the offset
		function longint row_sum(int base, longint x, longint y, longint z);
			return coef_of(base + 3) + ((coef_of(base) * x) >>> FRAC_BITS)
				+ ((coef_of(base + 1) * y) >>> FRAC_BITS)
				+ ((coef_of(base + 2) * z) >>> FRAC_BITS);
		endfunction

		// magnitude restoring division, truncated, saturated to the pixel width
		function logic signed [COORD_W-1:0] pixel_quotient(longint num, longint den);
			longint unsigned n, d, ip, rem, frac, mag;
			bit neg;
			int i;
			n = (num < 0) ? -num : num;
			d = (den < 0) ? -den : den;
			neg = (num < 0) != (den < 0);
			ip = n / d;
			rem = n % d;
			frac = 0;
			if (ip >= (64'd1 << (COORD_W - FRAC_BITS)))
				return neg ? Q_MIN : Q_MAX;
			for (i = 0; i < FRAC_BITS; i++) begin
				rem = rem << 1;
				frac = frac << 1;
				if (rem >= d) begin
					rem = rem - d;
					frac = frac | 1;
				end
			end
			mag = (ip << FRAC_BITS) | frac;
			if (neg)
				return (mag >= 64'h8000_0000) ? Q_MIN : COORD_W'(-longint'(mag));
			return (mag > 64'h7FFF_FFFF) ? Q_MAX : COORD_W'(mag);
		endfunction

		function void take_corner(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
			logic signed [COORD_W-1:0] z, logic last);
			longint u, v, w;
			longint unsigned aw;
			logic signed [COORD_W-1:0] cu, cv;
			bbox_t b;
			corners_seen++;
			if (z > 0) begin
				u = row_sum(0, x, y, z);
				v = row_sum(4, x, y, z);
				w = row_sum(8, x, y, z);
				aw = (w < 0) ? -w : w;
				// |w| under 1e-6 drops the corner
				if (!(aw < ONE && aw * 1000000 < ONE)) begin
					cu = pixel_quotient(u, w);
					cv = pixel_quotient(v, w);
					if (cu < min_u) min_u = cu;
					if (cu > max_u) max_u = cu;
					if (cv < min_v) min_v = cv;
					if (cv > max_v) max_v = cv;
					if (good_corners < 2)
						good_corners++;
				end
			end
			if (!last)
				return;
			if (good_corners < 2) begin
				b = '{NEG_ONE, NEG_ONE, NEG_ONE, NEG_ONE, 1'b0};
			end else begin
				b.box_left   = (min_u < 0) ? '0 : min_u;
				b.box_top    = (min_v < 0) ? '0 : min_v;
				b.box_right  = max_u;
				b.box_bottom = max_v;
				b.box_valid  = 1'b1;
			end
			pending_boxes.push_back(b);
			rearm();
		endfunction

		function void compare_field(string name, logic signed [COORD_W-1:0] e,
			logic signed [COORD_W-1:0] a);
			if (a !== e) begin
				errors++;
				$display("%0t: box %0d %s expected %0d (%h) got %0d (%h)", $time,
					boxes_checked, name, e, e, a, a);
			end
		endfunction

		function void check_box(bbox_t got);
			bbox_t e;
			if (pending_boxes.size() == 0) begin
				errors++;
				$display("%0t: unexpected box, expected none got %p", $time, got);
				return;
			end
			e = pending_boxes.pop_front();
			compare_field("box_left", e.box_left, got.box_left);
			compare_field("box_top", e.box_top, got.box_top);
			compare_field("box_right", e.box_right, got.box_right);
			compare_field("box_bottom", e.box_bottom, got.box_bottom);
			compare_field("box_valid", e.box_valid, got.box_valid);
			if (got.box_valid === 1'b1)
				valid_boxes++;
			boxes_checked++;
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	bcp_corner_if corner_ch ();
	bcp_box_if    box_ch ();

	box_corner_projection_bbox_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.corner    (corner_ch),
		.box       (box_ch)
	);

	bbox_tracker tracker = new();

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int holds_asked = 0;
	int holds_done = 0;
	int cfg_writes = 0;

	always #1 clk = ~clk;

	// receiver: random stalls, plus a long hold-off when one is asked for
	initial begin
		int hold_left;
		hold_left = 0;
		box_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				box_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				box_ch.ready <= 1'b0;
			end else if (holds_done != holds_asked) begin
				holds_done++;
				hold_left = HOLD_CYCLES;
				box_ch.ready <= 1'b0;
			end else begin
				box_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		bbox_t seen;
		if (arst_n && box_ch.valid && box_ch.ready) begin
			seen.box_left   = box_ch.box_left;
			seen.box_top    = box_ch.box_top;
			seen.box_right  = box_ch.box_right;
			seen.box_bottom = box_ch.box_bottom;
			seen.box_valid  = box_ch.box_valid;
			tracker.check_box(seen);
		end
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d boxes outstanding", tracker.pending_boxes.size());
		$display("DONE: errors detected");
		$finish;
	end

	task automatic offer_corner(input logic signed [COORD_W-1:0] x,
		input logic signed [COORD_W-1:0] y, input logic signed [COORD_W-1:0] z,
		input logic last);
		corner_ch.valid       <= 1'b1;
		corner_ch.corner_x    <= x;
		corner_ch.corner_y    <= y;
		corner_ch.corner_z    <= z;
		corner_ch.last_corner <= last;
		@(posedge clk);
		while (!corner_ch.ready)
			@(posedge clk);
		tracker.take_corner(x, y, z, last);
		if ($urandom_range(99) < send_idle_pct) begin
			corner_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	// block is idle once every box is back and the last corner has drained
	task automatic drain_and_settle();
		corner_ch.valid <= 1'b0;
		while (tracker.pending_boxes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_matrix(matrix_kind_t kind);
		logic signed [COEF_W-1:0] c [12];
		int i;
		foreach (c[j])
			c[j] = '0;
		case (kind)
			MAT_CAMERA, MAT_TILTED: begin
				c[0]  = 700 * ONE;
				c[2]  = 640 * ONE;
				c[5]  = 700 * ONE;
				c[6]  = 360 * ONE;
				c[10] = ONE;
				// depth mixed with x so that w can hit zero in front of the camera
				if (kind == MAT_TILTED)
					c[8] = ONE;
			end
			MAT_RAND_CAMERA: begin
				c[0]  = $urandom_range(100, 3000) * ONE;
				c[1]  = int'($urandom_range(0, 2 * ONE)) - ONE;
				c[2]  = $urandom_range(0, 1920) * ONE;
				c[3]  = (int'($urandom_range(0, 20000)) - 10000) * ONE;
				c[4]  = int'($urandom_range(0, 2 * ONE)) - ONE;
				c[5]  = $urandom_range(100, 3000) * ONE;
				c[6]  = $urandom_range(0, 1080) * ONE;
				c[7]  = (int'($urandom_range(0, 20000)) - 10000) * ONE;
				c[8]  = int'($urandom_range(0, ONE / 8)) - ONE / 16;
				c[9]  = int'($urandom_range(0, ONE / 8)) - ONE / 16;
				c[10] = ONE;
				c[11] = int'($urandom_range(0, 4 * ONE)) - 2 * ONE;
			end
			MAT_MAX: begin
				foreach (c[j])
					c[j] = Q_MAX;
			end
			MAT_MIN: begin
				foreach (c[j])
					c[j] = Q_MIN;
			end
			default: begin
				foreach (c[j])
					c[j] = $urandom;
			end
		endcase
		for (i = 0; i < NUM_REGS; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= REG_ORDER[i];
			cfg_data  <= {c[2*i+1], c[2*i]};
			tracker.write_reg(REG_ORDER[i], {c[2*i+1], c[2*i]});
			@(posedge clk);
		end
		cfg_index <= REG_UNUSED_A;
		cfg_data  <= {$urandom, $urandom};
		@(posedge clk);
		cfg_index <= REG_UNUSED_B;
		cfg_data  <= {$urandom, $urandom};
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_writes += NUM_REGS + 2;
	endtask

	task automatic set_idling(idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct = 0;
				recv_stall_pct <= 0;
			end
			IDLE_SEND: begin
				send_idle_pct = 45;
				recv_stall_pct <= 0;
			end
			IDLE_RECV: begin
				send_idle_pct = 0;
				recv_stall_pct <= 45;
			end
			default: begin
				send_idle_pct = 32;
				recv_stall_pct <= 32;
			end
		endcase
	endtask

	// corners of an axis-aligned box, now and then one corner broken
	task automatic send_box(input int n_corners);
		int cx, cy, cz, hx, hy, hz, x, y, z, k, r;
		cx = int'($urandom_range(0, 40 * ONE)) - 20 * ONE;
		cy = int'($urandom_range(0, 6 * ONE)) - 3 * ONE;
		if ($urandom_range(9) == 0)
			cz = int'($urandom_range(0, 10 * ONE)) - 5 * ONE;
		else
			cz = $urandom_range(ONE / 2, 60 * ONE);
		hx = $urandom_range(ONE / 4, 3 * ONE);
		hy = $urandom_range(ONE / 4, 2 * ONE);
		hz = $urandom_range(ONE / 4, 3 * ONE);
		for (k = 0; k < n_corners; k++) begin
			x = k[0] ? cx + hx : cx - hx;
			y = k[1] ? cy + hy : cy - hy;
			z = k[2] ? cz + hz : cz - hz;
			r = $urandom_range(99);
			if (r < 3)
				x = $urandom;
			else if (r < 6)
				z = -int'($urandom_range(0, ONE));
			else if (r < 8)
				z = $urandom_range(1, 16);
			offer_corner(x, y, z, k == n_corners - 1);
		end
	endtask

	task automatic random_traffic(input int n_items);
		int sent, n, j;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 78) begin
				n = ($urandom_range(9) < 7) ? 8 : $urandom_range(1, 8);
				send_box(n);
				sent += n;
			end else begin
				n = $urandom_range(1, 4);
				for (j = 0; j < n; j++)
					offer_corner($urandom, $urandom, $urandom, $urandom_range(3) == 0);
				sent += n;
			end
		end
		offer_corner($urandom, $urandom, $urandom, 1'b1);
	endtask

	task automatic run_phase(matrix_kind_t kind, idle_mode_t mode, int n_items);
		drain_and_settle();
		load_matrix(kind);
		set_idling(mode);
		random_traffic(n_items);
	endtask

	initial begin
		int i;
		arst_n                <= 1'b0;
		cfg_we                <= 1'b0;
		cfg_index             <= REG_COEF_0_1;
		cfg_data              <= '0;
		corner_ch.valid       <= 1'b0;
		corner_ch.corner_x    <= '0;
		corner_ch.corner_y    <= '0;
		corner_ch.corner_z    <= '0;
		corner_ch.last_corner <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all-zero matrix out of reset: w is zero, every corner is dropped
		set_idling(IDLE_NONE);
		offer_corner(ONE, 0, 2 * ONE, 1'b0);
		offer_corner(-ONE, ONE, 3 * ONE, 1'b1);

		drain_and_settle();
		load_matrix(MAT_CAMERA);
		offer_corner(ONE, ONE / 2, 10 * ONE, 1'b0);
		offer_corner(-ONE, -ONE / 2, 10 * ONE, 1'b0);
		offer_corner(2 * ONE, ONE, 20 * ONE, 1'b1);
		// one corner only
		offer_corner(0, 0, 5 * ONE, 1'b1);
		// depth zero, negative and most negative, then a single good corner
		offer_corner(3 * ONE, 0, 0, 1'b0);
		offer_corner(ONE, ONE, -ONE, 1'b0);
		offer_corner(Q_MAX, Q_MIN, Q_MIN, 1'b0);
		offer_corner(ONE, 0, 4 * ONE, 1'b1);
		// tiny depth and field extremes push the quotient into saturation
		offer_corner(ONE, 0, 1, 1'b0);
		offer_corner(-ONE, -ONE, 1, 1'b0);
		offer_corner(Q_MAX, Q_MIN, Q_MAX, 1'b0);
		offer_corner(Q_MIN, Q_MAX, 1, 1'b1);
		// negative minima clamp to zero, box closed by a dropped corner
		offer_corner(-10 * ONE, -5 * ONE, 2 * ONE, 1'b0);
		offer_corner(0, 0, 8 * ONE, 1'b0);
		offer_corner(5 * ONE, 0, -2 * ONE, 1'b1);

		drain_and_settle();
		load_matrix(MAT_TILTED);
		offer_corner(-3 * ONE, 0, 3 * ONE, 1'b0);
		offer_corner(ONE, 0, 4 * ONE, 1'b0);
		offer_corner(2 * ONE, ONE, 6 * ONE, 1'b1);

		run_phase(MAT_CAMERA, IDLE_NONE, 300);
		run_phase(MAT_RAND_CAMERA, IDLE_SEND, 300);
		run_phase(MAT_RAND_CAMERA, IDLE_RECV, 300);
		run_phase(MAT_CAMERA, IDLE_BOTH, 300);

		// receiver holds off while short boxes keep coming, input must back up
		drain_and_settle();
		load_matrix(MAT_CAMERA);
		set_idling(IDLE_NONE);
		holds_asked <= holds_asked + 1;
		for (i = 0; i < 60; i++)
			send_box($urandom_range(1, 2));

		run_phase(MAT_MAX, IDLE_BOTH, 120);
		run_phase(MAT_MIN, IDLE_NONE, 120);
		run_phase(MAT_RANDOM, IDLE_SEND, 120);
		run_phase(MAT_RANDOM, IDLE_RECV, 100);
		drain_and_settle();

		$display("covered %0d corners and %0d boxes (%0d with a valid bbox), %0d register writes",
			tracker.corners_seen, tracker.boxes_checked, tracker.valid_boxes, cfg_writes);
		$display("matrices: zero, camera, tilted, random camera, max, min, random; %0d errors",
			tracker.errors);
		if (tracker.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
